[rtl/mmcs_pkg.sv]
package mmcs_pkg;

   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

   // checksum modes
   localparam logic [1:0] ModeByteSum = 2'd0;
   localparam logic [1:0] ModeWord16  = 2'd1;
   localparam logic [1:0] ModeWord32  = 2'd2;
   localparam logic [1:0] ModeCrc32   = 2'd3;

   // register indexes
   localparam logic [1:0] CsrMode         = 2'd0;
   localparam logic [1:0] CsrLittleEndian = 2'd1;
   localparam logic [1:0] CsrInitialValue = 2'd2;

   localparam logic [1:0]  ResetMode         = ModeCrc32;
   localparam logic        ResetLittleEndian = 1'b0;
   localparam logic [31:0] ResetInitialValue = AllOnes;

   typedef struct packed {
      logic [1:0]  checksum_mode;
      logic        lsb_first;
      logic [31:0] initial_value;
   } cfg_type;

   typedef struct packed {
      logic [31:0] accumulator;
      logic [23:0] partial_word;
      logic [1:0]  byte_position;
   } state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
      logic [31:0] c;
      c = crc_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

[rtl/mmcs_update.sv]
module mmcs_update (
   input  mmcs_pkg::cfg_type   cfg,
   input  mmcs_pkg::state_type state_cur,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output mmcs_pkg::state_type state_nxt,
   output logic [31:0]         checksum_value
);

   logic [1:0]  pos;
   logic [23:0] pw_upd;
   logic        word_done;
   logic [7:0]  slot [4];
   logic [31:0] word;
   logic [31:0] acc_nxt;
   mmcs_pkg::state_type run_nxt;

   // word modes: slot the byte, close the word when full or on the last beat
   always_comb begin
      pos = (cfg.checksum_mode == mmcs_pkg::ModeWord16) ?
            {1'b0, state_cur.byte_position[0]} : state_cur.byte_position;
      pw_upd = state_cur.partial_word;
      case (pos)
         2'd0: pw_upd[7:0]   = data_byte;
         2'd1: pw_upd[15:8]  = data_byte;
         2'd2: pw_upd[23:16] = data_byte;
         default: pw_upd = state_cur.partial_word;
      endcase
      word_done = last_byte ||
                  ((cfg.checksum_mode == mmcs_pkg::ModeWord16) ? (pos == 2'd1) : (pos == 2'd3));
      for (int k = 0; k < 4; k++) begin
         if (k < 3 && 2'(k) < pos) begin
            slot[k] = pw_upd[8*k +: 8];
         end else if (2'(k) == pos) begin
            slot[k] = data_byte;
         end else begin
            slot[k] = 8'd0;
         end
      end
      if (cfg.checksum_mode == mmcs_pkg::ModeWord16) begin
         word = cfg.lsb_first ? {16'd0, slot[1], slot[0]} : {16'd0, slot[0], slot[1]};
      end else begin
         word = cfg.lsb_first ? {slot[3], slot[2], slot[1], slot[0]} :
                                {slot[0], slot[1], slot[2], slot[3]};
      end
   end

   always_comb begin
      run_nxt.accumulator   = state_cur.accumulator;
      run_nxt.partial_word  = 24'd0;
      run_nxt.byte_position = 2'd0;
      case (cfg.checksum_mode)
         mmcs_pkg::ModeByteSum: begin
            run_nxt.accumulator = state_cur.accumulator + {24'd0, data_byte};
         end
         mmcs_pkg::ModeWord16, mmcs_pkg::ModeWord32: begin
            if (word_done) begin
               run_nxt.accumulator = state_cur.accumulator + word;
            end else begin
               run_nxt.partial_word  = pw_upd;
               run_nxt.byte_position = pos + 2'd1;
            end
         end
         default: begin
            run_nxt.accumulator = mmcs_pkg::crc_byte(state_cur.accumulator, data_byte);
         end
      endcase
      acc_nxt = run_nxt.accumulator;
      checksum_value = (cfg.checksum_mode == mmcs_pkg::ModeCrc32) ? ~acc_nxt : acc_nxt;
      if (last_byte) begin
         state_nxt.accumulator   = cfg.initial_value;
         state_nxt.partial_word  = 24'd0;
         state_nxt.byte_position = 2'd0;
      end else begin
         state_nxt = run_nxt;
      end
   end

endmodule

[rtl/multi_mode_checksum_engine.sv]
// multi_mode_checksum_engine
// byte stream checksum: byte sum, 16-bit or 32-bit word sum, or reflected crc-32
// req channel: one byte per beat (req_data_byte, req_last_byte), valid/stall
// rsp channel: one 32-bit checksum per run, given for the beat marked last
// csr channel: valid/ready write of mode, word endianness and initial value;
//   csr_ready is always high; writing the initial value restarts the run;
//   csr_index 3 is ignored
// throughput: one byte per cycle while req_stall is low, the crc and sum update is a single
//   combinational pass from the accumulator register back to itself
// the checksum for the last byte is registered in the rsp output register, or in the skid while that one is held
// a short partial word at the end of a run is zero padded before it is added
// output register plus a one-entry skid: bytes keep flowing while a result
//   waits; req_stall is high while the skid holds a result, which happens
//   only when a second result arrives while rsp is stalled
// reset (synchronous): crc-32 mode, big endian, initial value all ones,
//   run restarted, no result pending
module multi_mode_checksum_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_checksum_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   mmcs_pkg::cfg_type   cfg_ff, cfg_in;
   mmcs_pkg::state_type state_ff, state_in, state_upd;
   logic [31:0] result;
   logic        req_accept;
   logic        csr_write;
   logic        res_valid;
   logic        out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_value_ff, skid_value_in;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign res_valid  = req_accept && req_last_byte;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   mmcs_update u_update (
      .cfg            (cfg_ff),
      .state_cur      (state_ff),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .state_nxt      (state_upd),
      .checksum_value (result)
   );

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      if (req_accept) begin
         state_in = state_upd;
      end
      if (csr_write) begin
         case (csr_index)
            mmcs_pkg::CsrMode:         cfg_in.checksum_mode = csr_data[1:0];
            mmcs_pkg::CsrLittleEndian: cfg_in.lsb_first     = csr_data[0];
            mmcs_pkg::CsrInitialValue: begin
               cfg_in.initial_value    = csr_data;
               state_in.accumulator    = csr_data;
               state_in.partial_word   = 24'd0;
               state_in.byte_position  = 2'd0;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // output register with one-entry skid behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      skid_valid_in = skid_valid_ff;
      skid_value_in = skid_value_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = skid_value_ff;
            skid_valid_in = res_valid;
            skid_value_in = result;
         end else begin
            rsp_valid_in = res_valid;
            rsp_value_in = result;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_value_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.checksum_mode   <= mmcs_pkg::ResetMode;
         cfg_ff.lsb_first       <= mmcs_pkg::ResetLittleEndian;
         cfg_ff.initial_value   <= mmcs_pkg::ResetInitialValue;
         state_ff.accumulator   <= mmcs_pkg::ResetInitialValue;
         state_ff.partial_word  <= 24'd0;
         state_ff.byte_position <= 2'd0;
         rsp_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      skid_value_ff <= skid_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_checksum_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the output register is empty");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> rsp_valid_ff)
      else $error("last byte taken but no result pending");

   a_word16_position: assert property (@(posedge clock) disable iff (reset)
      req_accept && cfg_ff.checksum_mode == mmcs_pkg::ModeWord16
      |=> state_ff.byte_position == 2'd0 || state_ff.byte_position == 2'd1)
      else $error("16-bit word mode left byte position beyond one");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   // index past the last register, writes to it are dropped
   localparam logic [1:0] CsrUnused = 2'd3;

   typedef enum logic {RowByte, RowReg} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_index;
      logic [31:0]  value;
      logic         last;
      logic         typed;
      logic [31:0]  typed_sum;
   } script_row_type;

   localparam int NumScriptRows = 35;

   localparam script_row_type Script [NumScriptRows] = '{
      // straight out of reset: crc-32, all ones start
      '{RowByte, '0, 32'h00, 1'b1, 1'b1, 32'hD202_EF8D},
      '{RowByte, '0, 32'hFF, 1'b1, 1'b1, 32'hFF00_0000},
      '{RowReg, mmcs_pkg::CsrMode, {30'd0, mmcs_pkg::ModeByteSum}, 1'b0, 1'b0, '0},
      '{RowReg, mmcs_pkg::CsrInitialValue, 32'h0, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'hFF, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'hFF, 1'b1, 1'b1, 32'h0000_01FE},
      '{RowReg, mmcs_pkg::CsrInitialValue, mmcs_pkg::AllOnes, 1'b0, 1'b0, '0},
      // sum wraps through zero
      '{RowByte, '0, 32'h01, 1'b1, 1'b1, 32'h0000_0000},
      '{RowReg, mmcs_pkg::CsrMode, {30'd0, mmcs_pkg::ModeWord16}, 1'b0, 1'b0, '0},
      '{RowReg, mmcs_pkg::CsrInitialValue, 32'h0, 1'b0, 1'b0, '0},
      // odd length run, last word zero padded
      '{RowByte, '0, 32'h12, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h34, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h56, 1'b1, 1'b1, 32'h0000_6834},
      '{RowReg, mmcs_pkg::CsrLittleEndian, 32'h1, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h12, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h34, 1'b1, 1'b1, 32'h0000_3412},
      '{RowReg, mmcs_pkg::CsrMode, {30'd0, mmcs_pkg::ModeWord32}, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'hAA, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'hBB, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'hCC, 1'b1, 1'b1, 32'h00CC_BBAA},
      '{RowReg, mmcs_pkg::CsrLittleEndian, 32'h0, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h01, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h02, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h03, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h04, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h05, 1'b1, 1'b1, 32'h0602_0304},
      // mode switched part way through a word
      '{RowByte, '0, 32'h11, 1'b0, 1'b0, '0},
      '{RowReg, mmcs_pkg::CsrMode, {30'd0, mmcs_pkg::ModeWord16}, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h22, 1'b1, 1'b0, '0},
      // new start value drops the run in progress
      '{RowByte, '0, 32'h77, 1'b0, 1'b0, '0},
      '{RowReg, mmcs_pkg::CsrInitialValue, 32'h10, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h80, 1'b1, 1'b0, '0},
      '{RowReg, CsrUnused, mmcs_pkg::AllOnes, 1'b0, 1'b0, '0},
      '{RowReg, mmcs_pkg::CsrMode, {30'd0, mmcs_pkg::ModeCrc32}, 1'b0, 1'b0, '0},
      '{RowByte, '0, 32'h5A, 1'b1, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_checksum_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor copy of registers and run state
   logic [1:0]  cfg_mode;
   logic        cfg_le;
   logic [31:0] cfg_init;
   logic [31:0] run_acc;
   logic [23:0] run_partial;
   logic [1:0]  run_pos;

   logic [31:0] expected_sums [$];
   logic [31:0] wanted_sum;
   int unsigned items_sent = 0;
   int unsigned mismatches = 0;
   int          hold_left = 0;
   bit          send_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   multi_mode_checksum_engine uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_checksum_value (rsp_checksum_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("tb_top: mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         c = (c[0] ^ b[k]) ? ((c >> 1) ^ mmcs_pkg::CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void restart_run();
      run_acc = cfg_init;
      run_partial = '0;
      run_pos = '0;
   endfunction

   // gathers a byte into a 2 or 4 byte word, adds the word once full or at end of run
   function automatic void add_word_byte(input logic [7:0] b, input int nbytes, input logic last);
      int          pos;
      logic [7:0]  lane [4];
      logic [31:0] word;
      pos = (nbytes == 2) ? int'(run_pos[0]) : int'(run_pos);
      if (pos < 3) begin
         run_partial[8*pos +: 8] = b;
      end
      if (pos + 1 < nbytes && !last) begin
         run_pos = 2'(pos + 1);
         return;
      end
      word = '0;
      for (int k = 0; k < 4; k++) begin
         lane[k] = (k < pos) ? run_partial[8*k +: 8] : ((k == pos) ? b : 8'h00);
      end
      for (int k = 0; k < nbytes; k++) begin
         if (cfg_le) begin
            word = word | ({24'd0, lane[k]} << (8 * k));
         end else begin
            word = {word[23:0], lane[k]};
         end
      end
      run_acc += word;
      run_partial = '0;
      run_pos = '0;
   endfunction

   function automatic bit step_checksum(input logic [7:0] b, input logic last,
                                        output logic [31:0] sum);
      sum = '0;
      case (cfg_mode)
         mmcs_pkg::ModeByteSum: begin
            run_acc += {24'd0, b};
            run_partial = '0;
            run_pos = '0;
         end
         mmcs_pkg::ModeWord16: add_word_byte(b, 2, last);
         mmcs_pkg::ModeWord32: add_word_byte(b, 4, last);
         default: begin
            run_acc = crc_update(run_acc, b);
            run_partial = '0;
            run_pos = '0;
         end
      endcase
      if (!last) begin
         return 1'b0;
      end
      sum = (cfg_mode == mmcs_pkg::ModeCrc32) ? ~run_acc : run_acc;
      restart_run();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (send_quiet || r < 12) begin
         return 0;
      end
      return (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input logic [31:0] typed_sum);
      int          gap;
      logic [31:0] sum;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (step_checksum(b, last, sum)) begin
         expected_sums.push_back(typed ? typed_sum : sum);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mmcs_pkg::CsrMode: cfg_mode = data[1:0];
         mmcs_pkg::CsrLittleEndian: cfg_le = data[0];
         mmcs_pkg::CsrInitialValue: begin
            cfg_init = data;
            restart_run();
         end
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      // every expected result has been taken, leave some margin
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
         hold_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(4, 24);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("checksum %h with none outstanding", rsp_checksum_value));
         end else begin
            wanted_sum = expected_sums.pop_front();
            if (rsp_checksum_value !== wanted_sum) begin
               report_mismatch($sformatf("checksum_value %h, wanted %h",
                                         rsp_checksum_value, wanted_sum));
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      script_row_type row;
      int             runs;
      int             len;
      bit             open_end;
      logic [31:0]    start_value;

      cfg_mode = mmcs_pkg::ResetMode;
      cfg_le = mmcs_pkg::ResetLittleEndian;
      cfg_init = mmcs_pkg::ResetInitialValue;
      restart_run();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NumScriptRows; i++) begin
         row = Script[i];
         if (row.kind == RowReg) begin
            wait_idle();
            csr_write(row.reg_index, row.value);
         end else begin
            send_byte(row.value[7:0], row.last, row.typed, row.typed_sum);
         end
      end

      while (items_sent < 1020) begin
         wait_idle();
         send_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1) == 1) begin
            csr_write(mmcs_pkg::CsrMode, $urandom);
         end
         if ($urandom_range(0, 2) == 0) begin
            csr_write(mmcs_pkg::CsrLittleEndian, $urandom);
         end
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 3))
               0: start_value = '0;
               1: start_value = mmcs_pkg::AllOnes;
               default: start_value = $urandom;
            endcase
            csr_write(mmcs_pkg::CsrInitialValue, start_value);
         end
         if ($urandom_range(0, 9) == 0) begin
            csr_write(CsrUnused, $urandom);
         end
         runs = $urandom_range(1, 10);
         for (int r = 0; r < runs; r++) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            // now and then a run is left open across the next register writes
            open_end = (r == runs - 1) && ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom), (i == len - 1) && !open_end, 1'b0, '0);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/mmcs_pkg.sv
rtl/mmcs_update.sv
rtl/multi_mode_checksum_engine.sv
sim/tb_top.sv
